[design/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types, widths and codes for the trinomial SPRT llr/decision core.
// ----------------------------------------------------------------------------
`default_nettype none

package tsl_pkg;

	// count field width (fixes the input word layout)
	localparam int COUNT_BITS        = 20;
	localparam int LLR_FRAC_BITS_DEF = 16;
	localparam int SCORE_FRAC        = 30;

	localparam int LLR_W = 32;
	localparam int DEC_W = 2;
	localparam int SC_W  = 31;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETUP_VALID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_NULL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_ALT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_HIGH  = 3'd4;

	// decision codes
	localparam logic [DEC_W-1:0] DEC_CONTINUE = 2'd0;
	localparam logic [DEC_W-1:0] DEC_ABOVE    = 2'd1;
	localparam logic [DEC_W-1:0] DEC_BELOW    = 2'd2;

	// datapath widths
	localparam int N_W  = COUNT_BITS + 2;        // w+d+l
	localparam int A_W  = COUNT_BITS + 3;        // 4w+2d, 4w+d
	localparam int S_W  = SC_W + 1;              // s0+s1
	localparam int E_W  = N_W + 1 + S_W;         // |A<<30 - 2Ns|
	localparam int D_W  = N_W + 2 + A_W;         // 4NB - A^2
	localparam int T1_W = E_W + SC_W;            // E*|s1-s0|
	localparam int T2_W = T1_W + N_W;            // *N
	localparam int T3_W = T2_W + N_W;            // *N
	localparam int Q_W  = LLR_W - 1;             // unsigned quotient bits
	localparam int R_W  = D_W + Q_W;             // divider remainder

	typedef struct packed {
		logic [COUNT_BITS-1:0] wins;
		logic [COUNT_BITS-1:0] draws;
		logic [COUNT_BITS-1:0] losses;
	} tsl_in_t;

	typedef struct packed {
		logic signed [LLR_W-1:0] llr_value;
		logic [DEC_W-1:0]        decision;
	} tsl_out_t;

	// side flags travelling with each word
	typedef struct packed {
		logic neg;   // result sign
		logic zero;  // force llr to zero
		logic ovf;   // quotient out of range
	} tsl_flag_t;

endpackage

`default_nettype wire

[design/trinomial_sprt_llr_decide_core.sv]
// ----------------------------------------------------------------------------
// trinomial_sprt_llr_decide_core
// Trinomial SPRT log-likelihood ratio (normal approximation) and decision.
// ----------------------------------------------------------------------------
// One word of win/draw/loss counts in, one word of llr (signed Q16.16,
// saturated) and decision out. A new word is taken every cycle unless the
// output buffer is full. A word passes the stages of sums and products,
// three two-stage wide multipliers, one range-check stage, a row of 31
// divider cells (one quotient bit each) and the output register. A two-word
// output buffer keeps taking words while a result waits; in_ready drops
// only when both are full. The user must write the configuration registers,
// used directly by the pipeline, only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module trinomial_sprt_llr_decide_core import tsl_pkg::*; #(
	parameter int LLR_FRAC_BITS = LLR_FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tsl_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tsl_out_t                  out_data,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	localparam int SH    = 2*SCORE_FRAC - 2 - LLR_FRAC_BITS;
	localparam int XH_W  = T3_W - SH;
	localparam int CMP_W = (XH_W > D_W) ? XH_W : D_W;
	localparam int X1_W  = N_W + D_W + $bits(tsl_flag_t);
	localparam int X3_W  = D_W + $bits(tsl_flag_t);

	// configuration registers
	logic                    setup_valid_q;
	logic [SC_W-1:0]         score_null_q;
	logic [SC_W-1:0]         score_alt_q;
	logic signed [LLR_W-1:0] bound_low_q;
	logic signed [LLR_W-1:0] bound_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_valid_q <= 1'b0;
			score_null_q  <= '0;
			score_alt_q   <= '0;
			bound_low_q   <= '0;
			bound_high_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SETUP_VALID: setup_valid_q <= cfg_wdata[0];
				REG_SCORE_NULL:  score_null_q  <= cfg_wdata[SC_W-1:0];
				REG_SCORE_ALT:   score_alt_q   <= cfg_wdata[SC_W-1:0];
				REG_BOUND_LOW:   bound_low_q   <= cfg_wdata;
				REG_BOUND_HIGH:  bound_high_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: held only while the output buffer is full
	logic adv;
	logic skid_v_q;
	assign adv      = !skid_v_q;
	assign in_ready = adv;

	// stage 1: sums and score difference
	logic            v_s1, v_s2, v_s3, v_s4;
	logic            v_m1, v_m2, v_m3;
	logic [N_W-1:0]  n_s1;
	logic [A_W-1:0]  a_s1, b_s1;
	logic [S_W-1:0]  s_s1;
	logic [SC_W-1:0] dmag_s1;
	logic            dneg_s1, zero_s1;
	logic [COUNT_BITS-1:0] w_in, d_in, l_in;

	assign w_in = in_data.wins;
	assign d_in = in_data.draws;
	assign l_in = in_data.losses;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1    <= N_W'(w_in) + N_W'(d_in) + N_W'(l_in);
			a_s1    <= (A_W'(w_in) << 2) + (A_W'(d_in) << 1);
			b_s1    <= (A_W'(w_in) << 2) + A_W'(d_in);
			s_s1    <= S_W'(score_null_q) + S_W'(score_alt_q);
			dneg_s1 <= score_alt_q < score_null_q;
			dmag_s1 <= (score_alt_q >= score_null_q) ? score_alt_q - score_null_q
			                                         : score_null_q - score_alt_q;
			zero_s1 <= !setup_valid_q || (w_in == '0) || (d_in == '0) || (l_in == '0);
		end
	end

	// stage 2: 2Ns, 4NB and A^2
	logic [E_W-1:0]  twons_s2;
	logic [D_W-1:0]  den4_s2, asq_s2;
	logic [A_W-1:0]  a_s2;
	logic [N_W-1:0]  n_s2;
	logic [SC_W-1:0] dmag_s2;
	logic            dneg_s2, zero_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			twons_s2 <= E_W'(n_s1) * E_W'(s_s1) * E_W'(2);
			den4_s2  <= (D_W'(n_s1) << 2) * D_W'(b_s1);
			asq_s2   <= D_W'(a_s1) * D_W'(a_s1);
			a_s2     <= a_s1;
			n_s2     <= n_s1;
			dmag_s2  <= dmag_s1;
			dneg_s2  <= dneg_s1;
			zero_s2  <= zero_s1;
		end
	end

	// stage 3: |E| with sign, denominator
	logic [E_W-1:0]  ash;
	logic [E_W-1:0]  e_s3;
	logic [D_W-1:0]  d_s3;
	logic [N_W-1:0]  n_s3;
	logic [SC_W-1:0] dmag_s3;
	tsl_flag_t       flg_s3;

	assign ash = E_W'(a_s2) << SCORE_FRAC;

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s3        <= (ash >= twons_s2) ? ash - twons_s2 : twons_s2 - ash;
			d_s3        <= den4_s2 - asq_s2;
			n_s3        <= n_s2;
			dmag_s3     <= dmag_s2;
			flg_s3.neg  <= (ash < twons_s2) ^ dneg_s2;
			flg_s3.zero <= zero_s2 || (den4_s2 <= asq_s2);
			flg_s3.ovf  <= 1'b0;
		end
	end

	// numerator products: E*dmag, then *N, then *N
	logic [T1_W-1:0] t1;
	logic [T2_W-1:0] t2;
	logic [T3_W-1:0] t3;
	logic [X1_W-1:0] x1, x2;
	logic [X3_W-1:0] x3;
	logic [N_W-1:0]  n_m1, n_m2;
	logic [D_W-1:0]  d_m1, d_m2;
	tsl_flag_t       flg_m1, flg_m2;

	tsl_wmul #(.A_WIDTH(SC_W), .B_WIDTH(E_W), .X_WIDTH(X1_W)) u_mul_e (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s3),
		.a(dmag_s3), .b(e_s3), .xin({n_s3, d_s3, flg_s3}),
		.vout(v_m1), .y(t1), .xout(x1)
	);
	assign {n_m1, d_m1, flg_m1} = x1;

	tsl_wmul #(.A_WIDTH(N_W), .B_WIDTH(T1_W), .X_WIDTH(X1_W)) u_mul_n1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_m1),
		.a(n_m1), .b(t1), .xin({n_m1, d_m1, flg_m1}),
		.vout(v_m2), .y(t2), .xout(x2)
	);
	assign {n_m2, d_m2, flg_m2} = x2;

	tsl_wmul #(.A_WIDTH(N_W), .B_WIDTH(T2_W), .X_WIDTH(X3_W)) u_mul_n2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_m2),
		.a(n_m2), .b(t2), .xin({d_m2, flg_m2}),
		.vout(v_m3), .y(t3), .xout(x3)
	);

	// stage 4: scale numerator, check quotient range
	logic [XH_W-1:0]  xh;
	logic [CMP_W-1:0] xh_top, d_ext;
	logic [D_W-1:0]   d_m3;
	tsl_flag_t        flg_m3;
	logic [R_W-1:0]   rem_s4;
	logic [D_W-1:0]   den_s4;
	tsl_flag_t        flg_s4;

	assign {d_m3, flg_m3} = x3;
	assign xh     = t3[T3_W-1:SH];
	assign xh_top = CMP_W'(xh >> Q_W);
	assign d_ext  = CMP_W'(d_m3);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s4      <= R_W'(xh);
			den_s4      <= d_m3;
			flg_s4.neg  <= flg_m3.neg;
			flg_s4.zero <= flg_m3.zero;
			flg_s4.ovf  <= xh_top >= d_ext;
		end
	end

	// divider cells, most significant quotient bit first
	logic            c_v   [Q_W+1];
	logic [R_W-1:0]  c_rem [Q_W+1];
	logic [D_W-1:0]  c_den [Q_W+1];
	logic [Q_W-1:0]  c_q   [Q_W+1];
	tsl_flag_t       c_flg [Q_W+1];

	assign c_v[0]   = v_s4;
	assign c_rem[0] = rem_s4;
	assign c_den[0] = den_s4;
	assign c_q[0]   = '0;
	assign c_flg[0] = flg_s4;

	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		tsl_div_cell #(.K(Q_W-1-i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .vin(c_v[i]),
			.rem_in(c_rem[i]), .den_in(c_den[i]), .q_in(c_q[i]), .flg_in(c_flg[i]),
			.vout(c_v[i+1]), .rem_out(c_rem[i+1]), .den_out(c_den[i+1]),
			.q_out(c_q[i+1]), .flg_out(c_flg[i+1])
		);
	end

	// sign, saturation and bound compare
	logic signed [LLR_W-1:0] llr;
	logic signed [LLR_W-1:0] q_pos;
	tsl_flag_t               fl;
	tsl_out_t                res;

	assign fl    = c_flg[Q_W];
	assign q_pos = signed'({1'b0, c_q[Q_W]});

	always_comb begin
		priority if (fl.zero) begin
			llr = '0;
		end else if (fl.ovf) begin
			llr = fl.neg ? signed'({1'b1, {(LLR_W-1){1'b0}}})
			             : signed'({1'b0, {(LLR_W-1){1'b1}}});
		end else begin
			llr = fl.neg ? -q_pos : q_pos;
		end
		res.llr_value = llr;
		priority if (!setup_valid_q) begin
			res.decision = DEC_CONTINUE;
		end else if (llr > bound_high_q) begin
			res.decision = DEC_ABOVE;
		end else if (llr < bound_low_q) begin
			res.decision = DEC_BELOW;
		end else begin
			res.decision = DEC_CONTINUE;
		end
	end

	// output register and skid word
	logic     out_v_q;
	tsl_out_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (adv && c_v[Q_W]) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && c_v[Q_W]) begin
			if (out_v_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (out_ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[design/tsl_wmul.sv]
// ----------------------------------------------------------------------------
// tsl_wmul
// Two-stage multiplier: narrow a times wide b, b cut into 32-bit slices.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_wmul import tsl_pkg::*; #(
	parameter int A_WIDTH = 32,
	parameter int B_WIDTH = 64,
	parameter int X_WIDTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vin,
	input  wire logic [A_WIDTH-1:0]         a,
	input  wire logic [B_WIDTH-1:0]         b,
	input  wire logic [X_WIDTH-1:0]         xin,
	output logic                            vout,
	output logic [A_WIDTH+B_WIDTH-1:0]      y,
	output logic [X_WIDTH-1:0]              xout
);

	localparam int CK   = 32;
	localparam int NC   = (B_WIDTH + CK - 1) / CK;
	localparam int P_W  = A_WIDTH + CK;
	localparam int SM_W = NC * CK + A_WIDTH;
	localparam int Y_W  = A_WIDTH + B_WIDTH;

	logic [NC*CK-1:0]   b_ext;
	logic [P_W-1:0]     pp_s1 [NC];
	logic [X_WIDTH-1:0] x_s1;
	logic               v_s1;
	logic [SM_W-1:0]    sum;
	logic [Y_W-1:0]     y_s2;
	logic [X_WIDTH-1:0] x_s2;
	logic               v_s2;

	assign b_ext = (NC*CK)'(b);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	// partial products of each slice
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				pp_s1[i] <= P_W'(a) * P_W'(b_ext[i*CK +: CK]);
			end
			x_s1 <= xin;
		end
	end

	// shifted sum of the slices
	always_comb begin
		sum = '0;
		for (int i = 0; i < NC; i++) begin
			sum = sum + (SM_W'(pp_s1[i]) << (i*CK));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= Y_W'(sum);
			x_s2 <= x_s1;
		end
	end

	assign vout = v_s2;
	assign y    = y_s2;
	assign xout = x_s2;

endmodule

`default_nettype wire

[design/tsl_div_cell.sv]
// ----------------------------------------------------------------------------
// tsl_div_cell
// One restoring division step: settles quotient bit K and passes the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_div_cell import tsl_pkg::*; #(
	parameter int K = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vin,
	input  wire logic [R_W-1:0]    rem_in,
	input  wire logic [D_W-1:0]    den_in,
	input  wire logic [Q_W-1:0]    q_in,
	input  wire tsl_flag_t         flg_in,
	output logic                   vout,
	output logic [R_W-1:0]         rem_out,
	output logic [D_W-1:0]         den_out,
	output logic [Q_W-1:0]         q_out,
	output tsl_flag_t              flg_out
);

	logic [R_W-1:0] den_sh;
	logic           ge;
	logic           v_q;
	logic [R_W-1:0] rem_q;
	logic [D_W-1:0] den_q;
	logic [Q_W-1:0] q_q;
	tsl_flag_t      flg_q;

	// trial subtract of the shifted divisor
	assign den_sh = R_W'(den_in) << K;
	assign ge     = rem_in >= den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? rem_in - den_sh : rem_in;
			den_q <= den_in;
			q_q   <= q_in | (Q_W'(ge) << K);
			flg_q <= flg_in;
		end
	end

	assign vout    = v_q;
	assign rem_out = rem_q;
	assign den_out = den_q;
	assign q_out   = q_q;
	assign flg_out = flg_q;

endmodule

`default_nettype wire

[design/tsl_checker.sv]
// ----------------------------------------------------------------------------
// tsl_checker
// Port-level checks for the trinomial SPRT core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_checker import tsl_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire tsl_out_t             out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// input side stops only when a result has been left waiting
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready dropped without output stall");

	// buffer full implies a result on show
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result presented");

	// no undefined decision code
	a_dec_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.decision == DEC_CONTINUE ||
		               out_data.decision == DEC_ABOVE ||
		               out_data.decision == DEC_BELOW))
		else $error("bad decision code");

endmodule

bind trinomial_sprt_llr_decide_core tsl_checker u_tsl_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trinomial SPRT llr/decision core against an in-bench predictor.
// Count words are sent through the valid/ready input while the result side
// stalls at random. Every result is compared field by field with the oldest
// predicted word. Several register settings are exercised, the extremes
// among them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import tsl_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	tsl_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	tsl_out_t             out_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// shadow copy of the register file
	logic                    sh_valid;
	logic [SC_W-1:0]         sh_s0, sh_s1;
	logic signed [LLR_W-1:0] sh_lo, sh_hi;

	tsl_out_t llr_expected_q[$];
	int       mismatches;
	int       words_sent;
	int       words_checked;
	bit       sink_busy_free;
	bit       src_busy_free;

	trinomial_sprt_llr_decide_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// llr and decision for one count word under the shadow registers
	function automatic tsl_out_t predict_llr(input tsl_in_t cw);
		logic [255:0] n, a, b, p, q, e, den4, asq, den, num, quo, dmag;
		logic         neg;
		logic signed [63:0] llr;
		tsl_out_t     r;
		llr = 0;
		r.decision = DEC_CONTINUE;
		if (sh_valid && cw.wins != 0 && cw.draws != 0 && cw.losses != 0) begin
			n = 256'(cw.wins) + 256'(cw.draws) + 256'(cw.losses);
			a = 4 * 256'(cw.wins) + 2 * 256'(cw.draws);
			b = 4 * 256'(cw.wins) + 256'(cw.draws);
			p = a << SCORE_FRAC;
			q = 2 * n * (256'(sh_s0) + 256'(sh_s1));
			if (p >= q) begin
				e = p - q;
				neg = 1'b0;
			end else begin
				e = q - p;
				neg = 1'b1;
			end
			if (sh_s1 >= sh_s0) dmag = 256'(sh_s1) - 256'(sh_s0);
			else begin
				dmag = 256'(sh_s0) - 256'(sh_s1);
				neg = ~neg;
			end
			den4 = 4 * n * b;
			asq = a * a;
			if (den4 > asq) begin
				den = (den4 - asq) << (2 * SCORE_FRAC);
				num = (4 * n * n * dmag * e) << LLR_FRAC_BITS_DEF;
				quo = num / den;
				// saturate to signed Q16.16
				if (quo >= 256'h8000_0000) llr = neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
				else llr = neg ? -$signed(64'(quo)) : $signed(64'(quo));
			end
		end
		if (sh_valid) begin
			if (llr > 64'(sh_hi)) r.decision = DEC_ABOVE;
			else if (llr < 64'(sh_lo)) r.decision = DEC_BELOW;
		end
		r.llr_value = llr[LLR_W-1:0];
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) return 0;
		if (pick < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (sink_busy_free) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 99) < 65) ? 1'b1 : ($urandom_range(0, 9) == 0);
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		tsl_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (llr_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with nothing pending: llr %h dec %0d",
						out_data.llr_value, out_data.decision);
			end else begin
				want = llr_expected_q.pop_front();
				words_checked++;
				if (out_data.llr_value !== want.llr_value ||
						out_data.decision !== want.decision) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: llr exp %h got %h, dec exp %0d got %0d",
							want.llr_value, out_data.llr_value,
							want.decision, out_data.decision);
				end
			end
		end
	end

	// write all five registers, one per cycle; caller is idle
	task automatic load_setup(input logic v, input logic [SC_W-1:0] s0, input logic [SC_W-1:0] s1,
			input logic signed [LLR_W-1:0] lo, input logic signed [LLR_W-1:0] hi);
		logic [CFG_W-1:0] vals[5];
		logic [CFG_IDX_W-1:0] idx[5];
		vals = '{CFG_W'(v), CFG_W'(s0), CFG_W'(s1), lo, hi};
		idx = '{REG_SETUP_VALID, REG_SCORE_NULL, REG_SCORE_ALT, REG_BOUND_LOW, REG_BOUND_HIGH};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		sh_valid = v;
		sh_s0 = s0;
		sh_s1 = s1;
		sh_lo = lo;
		sh_hi = hi;
		@(posedge clk);
	endtask

	// send one count word, then an optional gap
	task automatic send_word(input tsl_in_t cw);
		int unsigned g;
		in_valid <= 1'b1;
		in_data  <= cw;
		forever begin
			@(negedge clk);
			if (in_ready) break;
			@(posedge clk);
		end
		@(posedge clk);
		llr_expected_q.push_back(predict_llr(cw));
		words_sent++;
		g = src_busy_free ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (llr_expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic tsl_in_t counts(input int unsigned w, input int unsigned d,
			input int unsigned l);
		tsl_in_t c;
		c.wins = w[COUNT_BITS-1:0];
		c.draws = d[COUNT_BITS-1:0];
		c.losses = l[COUNT_BITS-1:0];
		return c;
	endfunction

	// a count with random magnitude so small and large values both occur
	function automatic int unsigned rand_count(input bit allow_zero);
		int unsigned bits, v;
		bits = $urandom_range(1, COUNT_BITS);
		v = $urandom & ((32'd1 << bits) - 1);
		if (!allow_zero && v == 0) v = 1;
		return v;
	endfunction

	task automatic test_directed();
		localparam int unsigned CMAX = (1 << COUNT_BITS) - 1;
		// reset values: setup invalid
		send_word(counts(5, 7, 3));
		drain();
		load_setup(1'b1, 31'h2000_0000, 31'h2100_0000, -32'sd193000, 32'sd193000);
		send_word(counts(0, 0, 0));
		send_word(counts(0, 4, 4));
		send_word(counts(4, 0, 4));
		send_word(counts(4, 4, 0));
		send_word(counts(1, 1, 1));
		send_word(counts(CMAX, CMAX, CMAX));
		send_word(counts(CMAX, 1, 1));
		send_word(counts(1, 1, CMAX));
		send_word(counts(1, CMAX, 1));
		send_word(counts(600, 1000, 400));
		drain();
		// saturation both ways, a wide score gap
		load_setup(1'b1, 31'd0, 31'h4000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_word(counts(CMAX, 1, 1));
		send_word(counts(1, 1, CMAX));
		send_word(counts(CMAX, CMAX, CMAX));
		drain();
		// alternative below null, crossed bounds
		load_setup(1'b1, 31'h4000_0000, 31'd0, 32'sd50000, -32'sd50000);
		send_word(counts(CMAX, 1, 1));
		send_word(counts(1, 1, CMAX));
		send_word(counts(0, 1, 1));
		drain();
		// equal scores, invalid setup with crossing bounds
		load_setup(1'b1, 31'h2000_0000, 31'h2000_0000, 32'sd1, -32'sd1);
		send_word(counts(900, 50, 10));
		drain();
		load_setup(1'b0, 31'h7FFF_FFFF, 31'd0, 32'sd1, -32'sd1);
		send_word(counts(CMAX, 1, 1));
		send_word(counts(0, 0, 0));
		drain();
	endtask

	task automatic test_random();
		logic [SC_W-1:0] s0, s1;
		logic signed [LLR_W-1:0] lo, hi;
		int unsigned per;
		for (int ph = 0; ph < 12; ph++) begin
			s0 = (ph == 0) ? 31'd0 : SC_W'($urandom_range(0, 32'h4000_0000));
			s1 = (ph == 1) ? 31'h4000_0000 : SC_W'($urandom_range(0, 32'h4000_0000));
			if (ph == 2) s1 = 31'h7FFF_FFFF;
			if (ph < 9 && s1 < s0) {s0, s1} = {s1, s0};
			lo = -$signed(32'($urandom_range(0, 32'h0010_0000)));
			hi = $signed(32'($urandom_range(0, 32'h0010_0000)));
			if (ph == 3) begin
				lo = 32'sh8000_0000;
				hi = 32'sh7FFF_FFFF;
			end
			if (ph == 4) {lo, hi} = {hi, lo};
			if (ph == 5) begin
				lo = $signed($urandom);
				hi = $signed($urandom);
			end
			load_setup(ph != 6, s0, s1, lo, hi);
			src_busy_free = (ph % 4 == 1);
			sink_busy_free = (ph % 4 == 2);
			per = 118;
			for (int k = 0; k < per; k++) begin
				// mostly complete counts, some with a zero field
				if ($urandom_range(0, 9) != 0)
					send_word(counts(rand_count(0), rand_count(0), rand_count(0)));
				else
					send_word(counts(rand_count(1), rand_count(1), rand_count(1)));
			end
			drain();
		end
		src_busy_free = 0;
		sink_busy_free = 0;
	endtask

	// run
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sh_valid = 1'b0;
		sh_s0 = '0;
		sh_s1 = '0;
		sh_lo = '0;
		sh_hi = '0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		sink_busy_free = 0;
		src_busy_free = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (llr_expected_q.size() != 0) mismatches++;
		$display("sent %0d count words, checked %0d results over 17 register settings",
			words_sent, words_checked);
		if (mismatches == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("testbench: errors");
		$finish;
	end

endmodule

`default_nettype wire
